### hdl/abblit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abblit_pkg
// Shared constants, register codes and helpers for the alpha blend blitter.
// ----------------------------------------------------------------------------
package abblit_pkg;

  localparam int MAX_DIM   = 2048;
  localparam int DIM_W     = 12;   // holds 1..MAX_DIM
  localparam int CNT_W     = 11;   // counters run 0..MAX_DIM-1
  localparam int POS_W     = 11;   // dest_x / dest_y
  localparam int CH_W      = 8;
  localparam int SRC_W     = 32;
  localparam int PIX_W     = 24;
  localparam int ADDR_W    = 24;
  localparam int BPP_SHIFT = 2;    // four bytes per pixel
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_POSITIONS = 3'd0,
    REG_DEST_X            = 3'd1,
    REG_DEST_Y            = 3'd2,
    REG_IMAGE_WIDTH       = 3'd3,
    REG_IMAGE_HEIGHT      = 3'd4,
    REG_FRAME_WIDTH       = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             write_enable;
  } blend_res_t;

  // zero counts as one, anything above the limit as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end
    return res;
  endfunction

  // floor(x / 255) for x up to 255*255
  function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

### hdl/abblit_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abblit_blend
// Channel extraction and per-channel alpha blend of one source pixel.
// ----------------------------------------------------------------------------
module abblit_blend (
  input  logic [abblit_pkg::SRC_W-1:0] src_pixel,
  input  logic [abblit_pkg::PIX_W-1:0] dest_pixel,
  input  logic [7:0]                   positions,
  output abblit_pkg::blend_res_t       res
);

  logic [abblit_pkg::CH_W-1:0] src_ch [4];
  logic [abblit_pkg::CH_W-1:0] r, g, b, a, a_inv;
  logic [abblit_pkg::CH_W-1:0] n_ch [3];
  logic [abblit_pkg::CH_W-1:0] e_ch [3];
  logic [abblit_pkg::CH_W-1:0] m_ch [3];
  logic [15:0]                 sum  [3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      src_ch[i] = src_pixel[i*8 +: 8];
    end
  end

  assign r = src_ch[positions[1:0]];
  assign g = src_ch[positions[3:2]];
  assign b = src_ch[positions[5:4]];
  assign a = src_ch[positions[7:6]];
  assign a_inv = abblit_pkg::ALPHA_OPAQUE - a;

  assign n_ch[0] = r;
  assign n_ch[1] = g;
  assign n_ch[2] = b;
  assign e_ch[0] = dest_pixel[23:16];
  assign e_ch[1] = dest_pixel[15:8];
  assign e_ch[2] = dest_pixel[7:0];

  // the weighted sum never exceeds 255*255, so 16 bits hold it
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i]  = 16'(n_ch[i]) * 16'(a) + 16'(e_ch[i]) * 16'(a_inv);
      m_ch[i] = abblit_pkg::div255(sum[i]);
    end
  end

  always_comb begin
    if (a == abblit_pkg::ALPHA_OPAQUE) begin
      res.pixel        = {r, g, b};
      res.write_enable = 1'b1;
    end else if (a == abblit_pkg::ALPHA_CLEAR) begin
      res.pixel        = dest_pixel;
      res.write_enable = 1'b0;
    end else begin
      res.pixel        = {m_ch[0], m_ch[1], m_ch[2]};
      res.write_enable = 1'b1;
    end
  end

endmodule

### hdl/alpha_blend_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_blend_blitter
// Pipeline: an accepted request passes through the input register, then
// the result register, before it shows on the output.
// Throughput: one request per cycle while out_stall is low, with the
// multiply and blend between the two registers.
// Reset: clears counters and valid flags and loads register reset values.
// ----------------------------------------------------------------------------
module alpha_blend_blitter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [abblit_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [abblit_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [abblit_pkg::SRC_W-1:0]        in_src_pixel,
  input  logic [abblit_pkg::PIX_W-1:0]        in_dest_pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [abblit_pkg::ADDR_W-1:0]       out_byte_address,
  output logic [abblit_pkg::PIX_W-1:0]        out_pixel,
  output logic                                out_write_enable,
  output logic                                out_last
);

  logic [7:0]                         chan_pos_r;
  logic [abblit_pkg::POS_W-1:0]       dest_x_r, dest_y_r;
  logic [abblit_pkg::DIM_W-1:0]       img_w_r, img_h_r, frame_w_r;
  logic [abblit_pkg::CNT_W-1:0]       col_r, row_r, col_nxt, row_nxt;
  logic [abblit_pkg::DIM_W-1:0]       w_eff, h_eff;
  logic                               col_end, row_end, in_acc, out_adv, s1_adv;

  logic                               s1_valid_r;
  logic [abblit_pkg::SRC_W-1:0]       s1_src_r;
  logic [abblit_pkg::PIX_W-1:0]       s1_dst_r;
  logic [abblit_pkg::DIM_W-1:0]       s1_ysum_r, s1_xsum_r;
  logic                               s1_last_r;

  logic                               out_valid_r;
  logic [abblit_pkg::ADDR_W-1:0]      addr_r, addr_nxt;
  logic [abblit_pkg::PIX_W-1:0]       pix_r;
  logic                               we_r, last_r;

  logic [abblit_pkg::ADDR_W-1:0]      row_base, pix_index;
  abblit_pkg::blend_res_t             blend;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_pos_r <= 8'd228;
      dest_x_r   <= '0;
      dest_y_r   <= '0;
      img_w_r    <= abblit_pkg::DIM_W'(1);
      img_h_r    <= abblit_pkg::DIM_W'(1);
      frame_w_r  <= abblit_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        abblit_pkg::REG_CHANNEL_POSITIONS: chan_pos_r <= cfg_data[7:0];
        abblit_pkg::REG_DEST_X:            dest_x_r   <= cfg_data[abblit_pkg::POS_W-1:0];
        abblit_pkg::REG_DEST_Y:            dest_y_r   <= cfg_data[abblit_pkg::POS_W-1:0];
        abblit_pkg::REG_IMAGE_WIDTH:       img_w_r    <= cfg_data;
        abblit_pkg::REG_IMAGE_HEIGHT:      img_h_r    <= cfg_data;
        abblit_pkg::REG_FRAME_WIDTH:       frame_w_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: each stage moves when the one after it has room
  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // raster counters
  assign w_eff   = abblit_pkg::clamp_dim(img_w_r);
  assign h_eff   = abblit_pkg::clamp_dim(img_h_r);
  assign col_end = ({1'b0, col_r} + abblit_pkg::DIM_W'(1)) >= w_eff;
  assign row_end = ({1'b0, row_r} + abblit_pkg::DIM_W'(1)) >= h_eff;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + abblit_pkg::CNT_W'(1);
      end else begin
        col_nxt = col_r + abblit_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_src_r  <= in_src_pixel;
      s1_dst_r  <= in_dest_pixel;
      s1_ysum_r <= {1'b0, dest_y_r} + {1'b0, row_r};
      s1_xsum_r <= {1'b0, dest_x_r} + {1'b0, col_r};
      s1_last_r <= col_end && row_end;
    end
  end

  // address and blend
  assign row_base  = abblit_pkg::ADDR_W'(s1_ysum_r) * abblit_pkg::ADDR_W'(frame_w_r);
  assign pix_index = row_base + abblit_pkg::ADDR_W'(s1_xsum_r);
  assign addr_nxt  = pix_index << abblit_pkg::BPP_SHIFT;

  abblit_blend u_blend (
    .src_pixel  (s1_src_r),
    .dest_pixel (s1_dst_r),
    .positions  (chan_pos_r),
    .res        (blend)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      addr_r <= addr_nxt;
      pix_r  <= blend.pixel;
      we_r   <= blend.write_enable;
      last_r <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_address = addr_r;
  assign out_pixel        = pix_r;
  assign out_write_enable = we_r;
  assign out_last         = last_r;

  // the last pixel of an image sends both counters home
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && col_end && row_end |=> col_r == '0 && row_r == '0)
    else $error("counters did not wrap after last pixel");

  // the row only moves when a row is finished
  a_row_steady: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !col_end |=> row_r == $past(row_r))
    else $error("row counter moved mid-row");

  // a request held in the input register is never dropped while output is blocked
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r && out_valid_r)
    else $error("request lost under stall");

endmodule
